>>> sv/client_demux_table_unit_macros.svh
// Assertion macros for the client demux table checker.
`ifndef CLIENT_DEMUX_TABLE_UNIT_MACROS_SVH
`define CLIENT_DEMUX_TABLE_UNIT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define CDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define CDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cdt_pkg.sv
// Types and constants shared by the client demux table modules.
`default_nettype none

package cdt_pkg;

	// Address field widths are fixed at two 64-bit words.
	localparam int ADDR_BYTES_MAX = 16;
	localparam int ADDR_W         = ADDR_BYTES_MAX * 8;

	// Hash offset basis (not the standard FNV-1a 64 basis); the prime is applied as shifts in the hash unit.
	localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

	typedef enum logic [2:0] {
		OUT_MATCHED       = 3'd0,
		OUT_REBOUND       = 3'd1,
		OUT_ALLOCATED     = 3'd2,
		OUT_DROP_NOT_JOIN = 3'd3,
		OUT_DROP_FULL     = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [63:0] addr_low;
		logic [63:0] addr_high;
		logic [4:0]  addr_length;
		logic        is_join;
		logic [31:0] join_nonce;
	} cdt_in_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [3:0]  client_index;
	} cdt_out_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] addr_low;
		logic [63:0] addr_high;
		logic [4:0]  addr_length;
		logic [31:0] nonce;
	} slot_rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_DONE
	} cdt_state_t;

endpackage

`default_nettype wire

>>> sv/cdt_hash.sv
// Byte-serial hash unit with FNV-1a 64 steps, one address byte per cycle.
`default_nettype none

module cdt_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cdt_pkg::ADDR_W-1:0] addr,
	input  logic [4:0]               len,
	output logic                     done,
	output logic [63:0]              key
);
	import cdt_pkg::*;

	logic        run_q;
	logic [4:0]  cnt_q;
	logic [63:0] h_q;
	logic [7:0]  byte_sel;
	logic [63:0] x;
	logic [63:0] h_next;

	// Fold one byte; the prime 2^40 + 0x1B3 is a sum of shifts
	always_comb begin
		byte_sel = addr[{cnt_q[3:0], 3'b000} +: 8];
		x        = h_q ^ {56'd0, byte_sel};
		h_next   = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
		done     = run_q && (cnt_q == len);
		key      = (len == 5'd0) ? 64'd0 : h_q;
	end

	// Advance the byte counter until the length is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 5'd0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= 5'd0;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// Hold the running hash
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= FNV_BASIS;
		end else if (run_q && !done) begin
			h_q <= h_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/cdt_slot_ram.sv
// Slot record memory: one write port, one registered read port.
`default_nettype none

module cdt_slot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  cdt_pkg::slot_rec_t wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output cdt_pkg::slot_rec_t rdata
);
	import cdt_pkg::*;

	slot_rec_t mem [DEPTH];

	// Write and read in the same clocked block; reads see the old entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/client_demux_table_unit.sv
// Top level of the client demux table: datagram address to client slot.
//
// Usage: present a datagram on cmd and raise start; the transfer happens at
// the rising edge where start is high and busy is low. The block masks the
// address to its length, hashes it byte-serially (FNV-1a 64 steps with the
// package basis), then reads the slot memory one slot per cycle, looking for
// an exact match, a slot with the same join nonce and the lowest free slot. A
// decision state follows, in which a rebind or allocation writes the slot record back.
// The result sits on result for exactly one cycle with done high; the
// receiver cannot stall it. Busy drops in that same cycle, so a new start is
// taken while the result is shown.
// N = slot count in use (at most MAX_SLOTS); the scan reads slots 0 to N-1.
// No new item is taken while one is in work; the hash loop (one byte a cycle)
// and the single memory read port set how long that work lasts.
// Writes land only in the decision cycle and reads for the next item start
// after hashing, so the controller serialises all memory accesses.
// Reset clears every slot valid bit at once and sets slots_in_use to 16;
// slot records need no clearing since only valid slots are compared.
// cfg_we / cfg_wdata write slots_in_use; write only while the block is idle.
`default_nettype none

module client_demux_table_unit #(
	parameter int MAX_SLOTS  = 16,
	parameter int ADDR_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cdt_pkg::cdt_in_t  cmd,
	output logic              busy,
	output logic              done,
	output cdt_pkg::cdt_out_t result,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_wdata
);
	import cdt_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	cdt_state_t           state_q, state_d;
	logic [4:0]           slots_q;
	logic [MAX_SLOTS-1:0] valid_q;

	logic [63:0]          lo_q, hi_q, key_q;
	logic [4:0]           len_q;
	logic                 join_q;
	logic [31:0]          nonce_q;

	logic [CNT_W-1:0]     rd_cnt_q;
	logic [CNT_W-1:0]     limit;
	logic                 issue;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	slot_rec_t            rdata_s1;

	logic                 match_hit_q, nonce_hit_q, free_hit_q;
	logic [IDX_W-1:0]     match_idx_q, nonce_idx_q, free_idx_q;
	logic                 hit_match, hit_nonce, hit_free;

	logic                 accept;
	logic                 hash_done;
	logic [63:0]          hash_key;
	logic [4:0]           len_sat;
	logic [ADDR_W-1:0]    addr_in, addr_m;

	logic                 wr_en, alloc;
	logic [IDX_W-1:0]     wr_idx;
	cdt_out_t             res_d;
	slot_rec_t            wr_rec;
	logic                 done_q;
	cdt_out_t             result_q;

	// Saturate the length and clear the bytes beyond it
	always_comb begin
		addr_in = {cmd.addr_high, cmd.addr_low};
		len_sat = (cmd.addr_length > 5'(ADDR_BYTES)) ? 5'(ADDR_BYTES) : cmd.addr_length;
		for (int b = 0; b < ADDR_BYTES_MAX; b++) begin
			addr_m[b*8 +: 8] = (5'(b) < len_sat) ? addr_in[b*8 +: 8] : 8'd0;
		end
	end

	// Clip the slot count to the table depth
	always_comb begin
		if (32'(slots_q) > MAX_SLOTS) begin
			limit = CNT_W'(MAX_SLOTS);
		end else begin
			limit = CNT_W'(slots_q);
		end
	end

	assign accept = start && (state_q == ST_IDLE);
	assign issue  = (state_q == ST_SCAN) && (rd_cnt_q < limit);

	cdt_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.addr   ({hi_q, lo_q}),
		.len    (len_q),
		.done   (hash_done),
		.key    (hash_key)
	);

	cdt_slot_ram #(
		.DEPTH (MAX_SLOTS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_rec),
		.re    (issue),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rdata_s1)
	);

	// Compare the slot read in the previous cycle
	always_comb begin
		hit_match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (key_q != 64'd0)
			&& (rdata_s1.key == key_q) && (rdata_s1.addr_length == len_q)
			&& (rdata_s1.addr_low == lo_q) && (rdata_s1.addr_high == hi_q);
		hit_nonce = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rdata_s1.nonce == nonce_q);
		hit_free  = cmp_vld_s1 && !valid_q[cmp_idx_s1];
	end

	// Next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Decide the outcome and the slot to write back
	always_comb begin
		wr_en              = 1'b0;
		alloc              = 1'b0;
		wr_idx             = nonce_idx_q;
		res_d.outcome      = OUT_DROP_NOT_JOIN;
		res_d.client_index = 4'd0;
		priority if (match_hit_q) begin
			res_d.outcome      = OUT_MATCHED;
			res_d.client_index = 4'(match_idx_q);
		end else if (join_q && nonce_hit_q) begin
			wr_en              = (state_q == ST_DONE);
			res_d.outcome      = OUT_REBOUND;
			res_d.client_index = 4'(nonce_idx_q);
		end else if (join_q && free_hit_q) begin
			wr_en              = (state_q == ST_DONE);
			alloc              = (state_q == ST_DONE);
			wr_idx             = free_idx_q;
			res_d.outcome      = OUT_ALLOCATED;
			res_d.client_index = 4'(free_idx_q);
		end else if (join_q) begin
			res_d.outcome      = OUT_DROP_FULL;
		end else begin
			res_d.outcome      = OUT_DROP_NOT_JOIN;
		end
		wr_rec.key         = key_q;
		wr_rec.addr_low    = lo_q;
		wr_rec.addr_high   = hi_q;
		wr_rec.addr_length = len_q;
		wr_rec.nonce       = nonce_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slots_q     <= 5'd16;
			valid_q     <= '0;
			done_q      <= 1'b0;
			rd_cnt_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			match_hit_q <= 1'b0;
			nonce_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			if (alloc) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (state_q == ST_HASH) begin
				rd_cnt_q    <= '0;
				cmp_vld_s1  <= 1'b0;
				match_hit_q <= 1'b0;
				nonce_hit_q <= 1'b0;
				free_hit_q  <= 1'b0;
			end else begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (hit_match && !match_hit_q) begin
					match_hit_q <= 1'b1;
				end
				if (hit_nonce && !nonce_hit_q) begin
					nonce_hit_q <= 1'b1;
				end
				if (hit_free && !free_hit_q) begin
					free_hit_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers: item, key, lowest hit indexes and result
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q    <= addr_m[63:0];
			hi_q    <= addr_m[127:64];
			len_q   <= len_sat;
			join_q  <= cmd.is_join;
			nonce_q <= cmd.join_nonce;
		end
		if ((state_q == ST_HASH) && hash_done) begin
			key_q <= hash_key;
		end
		if (issue) begin
			cmp_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (hit_match && !match_hit_q) begin
			match_idx_q <= cmp_idx_s1;
		end
		if (hit_nonce && !nonce_hit_q) begin
			nonce_idx_q <= cmp_idx_s1;
		end
		if (hit_free && !free_hit_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_DONE) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> sv/cdt_checker.sv
// Port-level checker for the client demux table, bound to the top level.
`default_nettype none

`include "client_demux_table_unit_macros.svh"

module cdt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input cdt_pkg::cdt_out_t result
);
	import cdt_pkg::*;

	// A dropped datagram carries slot zero
	`CDT_ASSERT_IMP(a_drop_index, clk, arst_n, done && (result.outcome == OUT_DROP_NOT_JOIN || result.outcome == OUT_DROP_FULL), result.client_index == 4'd0, "dropped result with nonzero slot")

	// An accepted transfer makes the block busy
	`CDT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "transfer accepted but block not busy")

	// A result follows a busy cycle and arrives with the block idle
	`CDT_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy, "result without prior work")

	// The result strobe lasts one cycle
	`CDT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held over two cycles")

endmodule

bind client_demux_table_unit cdt_checker u_cdt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
